### hdl/mlfd_pkg.sv
// ----------------------------------------------------------------------------
// Marker/length frame deframer package
// Shared widths, register indexes, result kinds and structs of the deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  // Largest payload length the block ever accepts, whatever max_payload says.
  localparam int MaxFrameBytes = 1024;

  // Width of the remaining-byte counter; it never holds more than MaxFrameBytes.
  localparam int LeftW = $clog2(MaxFrameBytes + 1);

  localparam int ByteW     = 8;
  localparam int LenW      = 16;
  localparam int MaxPayW   = 15;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 15;
  localparam int KindW     = 2;

  localparam logic [MaxPayW-1:0] MaxPayloadReset = MaxPayW'(1024);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_FIRST  = 3'd0,
    CFG_START_SECOND = 3'd1,
    CFG_END_FIRST    = 3'd2,
    CFG_END_SECOND   = 3'd3,
    CFG_MAX_PAYLOAD  = 3'd4
  } cfg_idx_e;

  // Kinds of result request.
  typedef enum logic [KindW-1:0] {
    KIND_DATA    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD_END = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0]   start_first;
    logic [ByteW-1:0]   start_second;
    logic [ByteW-1:0]   end_first;
    logic [ByteW-1:0]   end_second;
    logic [MaxPayW-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
  } result_t;

endpackage

### hdl/mlfd_byte_if.sv
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel that carries one received byte per request.
// ----------------------------------------------------------------------------
interface mlfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

### hdl/mlfd_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one deframer result per request.
// ----------------------------------------------------------------------------
interface mlfd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_data;

  modport source (output valid, output out_kind, output out_data, input ready);
  modport sink (input valid, input out_kind, input out_data, output ready);
endinterface

### hdl/mlfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds the marker bytes and the payload length limit, written by index.
// ----------------------------------------------------------------------------
module mlfd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mlfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mlfd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output mlfd_pkg::cfg_t                cfg_o
);

  mlfd_pkg::cfg_t cfg_q;
  mlfd_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mlfd_pkg::CFG_START_FIRST:  cfg_d.start_first  = cfg_wdata_i[7:0];
        mlfd_pkg::CFG_START_SECOND: cfg_d.start_second = cfg_wdata_i[7:0];
        mlfd_pkg::CFG_END_FIRST:    cfg_d.end_first    = cfg_wdata_i[7:0];
        mlfd_pkg::CFG_END_SECOND:   cfg_d.end_second   = cfg_wdata_i[7:0];
        mlfd_pkg::CFG_MAX_PAYLOAD:  cfg_d.max_payload  = cfg_wdata_i[mlfd_pkg::MaxPayW-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first  <= '0;
      cfg_q.start_second <= '0;
      cfg_q.end_first    <= '0;
      cfg_q.end_second   <= '0;
      cfg_q.max_payload  <= mlfd_pkg::MaxPayloadReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/mlfd_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Input byte register and the frame phase logic that turns one byte into at
// most one result request.
// ----------------------------------------------------------------------------
module mlfd_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [mlfd_pkg::ByteW-1:0]  in_byte_i,
  output logic                        in_ready_o,
  input  mlfd_pkg::cfg_t              cfg_i,
  input  logic                        take_i,
  output logic                        res_valid_o,
  output mlfd_pkg::result_t           res_o
);

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_END1    = 3'd5,
    PH_END2    = 3'd6
  } phase_e;

  logic                         vld_q;
  logic [mlfd_pkg::ByteW-1:0]   byte_q;
  phase_e                       phase_q, phase_d;
  logic [mlfd_pkg::ByteW-1:0]   len_lo_q, len_lo_d;
  logic [mlfd_pkg::LeftW-1:0]   left_q, left_d;
  logic                         adv;
  logic                         in_take;
  logic [mlfd_pkg::LenW-1:0]    len;
  logic                         reject;
  logic [mlfd_pkg::LeftW-1:0]   left_dec;

  // The held byte moves on whenever the result stage can take a request.
  assign adv        = vld_q & take_i;
  assign in_ready_o = ~vld_q | adv;
  assign in_take    = in_valid_i & in_ready_o;

  assign len      = {byte_q, len_lo_q};
  assign reject   = len[mlfd_pkg::LenW-1]
                  | (len > {1'b0, cfg_i.max_payload})
                  | (len > mlfd_pkg::LenW'(mlfd_pkg::MaxFrameBytes));
  assign left_dec = left_q - mlfd_pkg::LeftW'(1);

  always_comb begin
    phase_d     = phase_q;
    len_lo_d    = len_lo_q;
    left_d      = left_q;
    res_valid_o = 1'b0;
    res_o.kind  = mlfd_pkg::KIND_DATA;
    res_o.data  = '0;
    if (adv) begin
      case (phase_q)
        PH_HUNT2: begin
          if (byte_q == cfg_i.start_second) begin
            phase_d = PH_LEN_LO;
          end else if (byte_q == cfg_i.start_first) begin
            phase_d = PH_HUNT2;
          end else begin
            phase_d = PH_HUNT1;
          end
        end
        PH_LEN_LO: begin
          len_lo_d = byte_q;
          phase_d  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (reject) begin
            phase_d     = PH_HUNT1;
            left_d      = '0;
            res_valid_o = 1'b1;
            res_o.kind  = mlfd_pkg::KIND_REJECT;
          end else begin
            left_d  = len[mlfd_pkg::LeftW-1:0];
            phase_d = (len == '0) ? PH_END1 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          left_d      = left_dec;
          phase_d     = (left_dec == '0) ? PH_END1 : PH_PAYLOAD;
          res_valid_o = 1'b1;
          res_o.kind  = mlfd_pkg::KIND_DATA;
          res_o.data  = byte_q;
        end
        PH_END1: begin
          if (byte_q == cfg_i.end_first) begin
            phase_d = PH_END2;
          end else begin
            phase_d     = PH_HUNT1;
            res_valid_o = 1'b1;
            res_o.kind  = mlfd_pkg::KIND_BAD_END;
          end
        end
        PH_END2: begin
          phase_d     = PH_HUNT1;
          res_valid_o = 1'b1;
          res_o.kind  = (byte_q == cfg_i.end_second) ? mlfd_pkg::KIND_GOOD
                                                     : mlfd_pkg::KIND_BAD_END;
        end
        default: begin
          phase_d = (byte_q == cfg_i.start_first) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      phase_q  <= PH_HUNT1;
      len_lo_q <= '0;
      left_q   <= '0;
    end else begin
      if (in_take) begin
        vld_q <= 1'b1;
      end else if (adv) begin
        vld_q <= 1'b0;
      end
      phase_q  <= phase_d;
      len_lo_q <= len_lo_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= in_byte_i;
    end
  end

  // A payload phase always has at least one byte left to pass.
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q != '0)
    else $error("payload phase with no bytes left");

  // The remaining count never exceeds the hard frame limit.
  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= mlfd_pkg::LeftW'(mlfd_pkg::MaxFrameBytes))
    else $error("remaining byte count above frame limit");

  // A rejected length sends the parser back to hunting.
  a_reject_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == mlfd_pkg::KIND_REJECT |=> phase_q == PH_HUNT1)
    else $error("no return to hunting after length reject");

  // Only payload requests carry a nonzero data byte.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind != mlfd_pkg::KIND_DATA |-> res_o.data == '0)
    else $error("nonzero data on a status request");

endmodule

### hdl/mlfd_out_stage.sv
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module mlfd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  mlfd_pkg::result_t res_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mlfd_pkg::result_t out_res_o
);

  logic              valid_q;
  mlfd_pkg::result_t res_q;

  // Room when empty or when the held request leaves in this cycle.
  assign take_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

### hdl/marker_length_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// Marker/length frame deframer
// Top level: configuration registers, parser and result register.
// ----------------------------------------------------------------------------
// The deframer takes one received byte per request and sustains one byte per
// clock cycle as long as the result side keeps taking requests. A byte is
// held in an input register, where the frame phase logic (a
// few byte compares, a 16-bit length check and a small down counter) decides
// the next phase and at most one result; that result lands in the result
// register and is offered from there. The input side is ready while the
// input register is empty, or while the result register is empty or being
// drained, so a waiting result stops the next byte only once the input
// register is full. Results are a payload byte, a good frame, a bad
// end marker, or a rejected length (bit 15 set, above max_payload, or above
// the built-in limit of 1024 bytes); after any of the last three the block
// hunts for the start marker again at the next byte. Registers are written
// through a plain write port and must only change while no frame is in
// flight and the result register has drained.
// ----------------------------------------------------------------------------
module marker_length_frame_deframer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mlfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mlfd_pkg::CfgDataW-1:0] cfg_wdata_i,
  mlfd_byte_if.sink                     in_i,
  mlfd_result_if.source                 out_o
);

  mlfd_pkg::cfg_t    cfg;
  mlfd_pkg::result_t res;
  mlfd_pkg::result_t out_res;
  logic              res_valid;
  logic              take;

  // Marker bytes and length limit.
  mlfd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input byte register and frame phase tracking.
  mlfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_byte_i   (in_i.in_byte),
    .in_ready_o  (in_i.ready),
    .cfg_i       (cfg),
    .take_i      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register toward the downstream side.
  mlfd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .take_o      (take),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (out_res)
  );

  assign out_o.out_kind = out_res.kind;
  assign out_o.out_data = out_res.data;

endmodule

### tb/mlfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer result checker
// Watches the byte, result and register write ports of the deframer, keeps
// its own copy of the frame parser, and compares every result request with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module mlfd_checker
  import mlfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  mlfd_byte_if                byte_mon_i,
  mlfd_result_if              res_mon_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o,
  output logic                in_frame_o,
  output int unsigned         kind_seen_o [4]
);

  localparam int unsigned MaxShown = 30;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    LEN_LOW,
    LEN_HIGH,
    PAYLOAD,
    END_FIRST,
    END_SECOND
  } parse_phase_e;

  // Parser copy; updated with blocking assignments inside the clocked block
  // and published to the stimulus side with nonblocking ones.
  parse_phase_e        frame_phase;
  logic [LenW-1:0]     frame_len;
  logic [MaxPayW-1:0]  payload_left;
  cfg_t                regs;
  result_t             expected_results [$];
  int unsigned         errors = 0;
  int unsigned         kinds [4] = '{0, 0, 0, 0};

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MaxShown) begin
      $display("[%0t] deframer mismatch: %s", $time, what);
    end
  endtask

  task automatic parse_byte(input logic [ByteW-1:0] b);
    result_t r;
    bit      emit;
    emit   = 1'b0;
    r.kind = KIND_DATA;
    r.data = '0;
    case (frame_phase)
      HUNT_SECOND: begin
        if (b == regs.start_second) begin
          frame_phase = LEN_LOW;
        end else if (b == regs.start_first) begin
          frame_phase = HUNT_SECOND;
        end else begin
          frame_phase = HUNT_FIRST;
        end
      end
      LEN_LOW: begin
        frame_len   = {8'h00, b};
        frame_phase = LEN_HIGH;
      end
      LEN_HIGH: begin
        frame_len = {b, frame_len[7:0]};
        if (frame_len[LenW-1] || frame_len > {1'b0, regs.max_payload} ||
            frame_len > LenW'(MaxFrameBytes)) begin
          frame_phase  = HUNT_FIRST;
          payload_left = '0;
          emit         = 1'b1;
          r.kind       = KIND_REJECT;
        end else begin
          payload_left = frame_len[MaxPayW-1:0];
          frame_phase  = (payload_left == '0) ? END_FIRST : PAYLOAD;
        end
      end
      PAYLOAD: begin
        payload_left = payload_left - 1'b1;
        if (payload_left == '0) begin
          frame_phase = END_FIRST;
        end
        emit   = 1'b1;
        r.data = b;
      end
      END_FIRST: begin
        if (b == regs.end_first) begin
          frame_phase = END_SECOND;
        end else begin
          frame_phase = HUNT_FIRST;
          emit        = 1'b1;
          r.kind      = KIND_BAD_END;
        end
      end
      END_SECOND: begin
        frame_phase = HUNT_FIRST;
        emit        = 1'b1;
        r.kind      = (b == regs.end_second) ? KIND_GOOD : KIND_BAD_END;
      end
      default: begin
        frame_phase = (b == regs.start_first) ? HUNT_SECOND : HUNT_FIRST;
      end
    endcase
    if (emit) begin
      expected_results.push_back(r);
    end
  endtask

  task automatic check_result(input logic [KindW-1:0] kind, input logic [ByteW-1:0] data);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result kind %0d data %02h with nothing outstanding",
                                kind, data));
    end else begin
      want = expected_results.pop_front();
      if (kind !== want.kind) begin
        report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
      end
      if (data !== want.data) begin
        report_mismatch($sformatf("data %02h, expected %02h (kind %0d)",
                                  data, want.data, want.kind));
      end
      kinds[want.kind]++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_phase       = HUNT_FIRST;
      frame_len         = '0;
      payload_left      = '0;
      regs.start_first  = '0;
      regs.start_second = '0;
      regs.end_first    = '0;
      regs.end_second   = '0;
      regs.max_payload  = MaxPayloadReset;
      expected_results.delete();
      pending_o    <= 0;
      in_frame_o   <= 1'b0;
      mismatches_o <= errors;
      kind_seen_o  <= kinds;
    end else begin
      if ($isunknown({byte_mon_i.ready, res_mon_i.valid})) begin
        report_mismatch("handshake output is unknown");
      end
      if (byte_mon_i.valid && byte_mon_i.ready) begin
        parse_byte(byte_mon_i.in_byte);
      end
      if (res_mon_i.valid && res_mon_i.ready) begin
        check_result(res_mon_i.out_kind, res_mon_i.out_data);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_FIRST:  regs.start_first  = cfg_wdata_i[ByteW-1:0];
          CFG_START_SECOND: regs.start_second = cfg_wdata_i[ByteW-1:0];
          CFG_END_FIRST:    regs.end_first    = cfg_wdata_i[ByteW-1:0];
          CFG_END_SECOND:   regs.end_second   = cfg_wdata_i[ByteW-1:0];
          CFG_MAX_PAYLOAD:  regs.max_payload  = cfg_wdata_i[MaxPayW-1:0];
          default: ;
        endcase
      end
      pending_o    <= expected_results.size();
      in_frame_o   <= (frame_phase != HUNT_FIRST);
      mismatches_o <= errors;
      kind_seen_o  <= kinds;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer testbench
// Drives byte requests and register writes into the marker/length frame
// deframer under several register settings and idling patterns, while a
// separate checker predicts and compares every result request.
// ----------------------------------------------------------------------------
module testbench;
  import mlfd_pkg::*;

  // The slowest correct run sends under 2000 bytes; even with long random
  // gaps on both sides and the flushes between settings it stays far below
  // this limit, so the limit only trips on a hang.
  localparam int unsigned CycleLimit  = 400000;
  // A byte reaches a result through the input and result registers; a byte that
  // causes no result may still sit in the block after the last expected result.
  localparam int unsigned DrainCycles = 6;

  typedef enum int {
    END_OK,
    END_BAD_FIRST,
    END_BAD_SECOND
  } end_fault_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  mlfd_byte_if   byte_ch ();
  mlfd_result_if res_ch ();

  int unsigned mismatches;
  int unsigned pending;
  logic        in_frame;
  int unsigned kind_seen [4];

  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned settings    = 1;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Register values as the stimulus side last wrote them; the checker keeps
  // its own copy taken from the write port.
  cfg_t cur;

  marker_length_frame_deframer_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (byte_ch),
    .out_o      (res_ch)
  );

  mlfd_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .byte_mon_i  (byte_ch),
    .res_mon_i   (res_ch),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .in_frame_o  (in_frame),
    .kind_seen_o (kind_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // The run ends here if anything hangs: a stuck handshake or a result that
  // never shows up both keep the stimulus from reaching its end.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("TB_ERROR");
    $finish;
  end

  // The result side takes requests at random; the stall rate can change from
  // one setting to the next.
  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Offers one byte and returns at the clock edge at which it was taken. The
  // valid line is left high, so back-to-back calls keep the stream dense.
  task automatic push_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) begin
      @(posedge clk_i);
    end
    bytes_sent++;
  endtask

  // Writes all five registers in one burst of cycles. With stray set, the
  // unused indexes get random data afterwards; the block must ignore them.
  task automatic apply_config(input logic [ByteW-1:0] sf, input logic [ByteW-1:0] ss,
                              input logic [ByteW-1:0] ef, input logic [ByteW-1:0] es,
                              input logic [MaxPayW-1:0] maxp, input bit stray);
    logic [CfgDataW-1:0] vals [2**CfgIdxW];
    int                  last;
    vals[CFG_START_FIRST]  = CfgDataW'(sf);
    vals[CFG_START_SECOND] = CfgDataW'(ss);
    vals[CFG_END_FIRST]    = CfgDataW'(ef);
    vals[CFG_END_SECOND]   = CfgDataW'(es);
    vals[CFG_MAX_PAYLOAD]  = CfgDataW'(maxp);
    for (int i = int'(CFG_MAX_PAYLOAD) + 1; i < 2**CfgIdxW; i++) begin
      vals[i] = CfgDataW'($urandom);
    end
    last = stray ? 2**CfgIdxW - 1 : int'(CFG_MAX_PAYLOAD);
    cfg_we <= 1'b1;
    for (int i = 0; i <= last; i++) begin
      cfg_idx   <= CfgIdxW'(i);
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    cur.start_first  = sf;
    cur.start_second = ss;
    cur.end_first    = ef;
    cur.end_second   = es;
    cur.max_payload  = maxp;
    settings++;
  endtask

  // Longest length the block should accept under the current setting.
  function automatic int length_limit();
    return (int'(cur.max_payload) < MaxFrameBytes) ? int'(cur.max_payload) : MaxFrameBytes;
  endfunction

  // Most lengths are short so many frames fit into the run; some sit just
  // above the limit, some at it (13 to 48 if it is larger), some set bit 15.
  function automatic logic [LenW-1:0] pick_length();
    int lim;
    int r;
    lim = length_limit();
    r   = $urandom_range(99);
    if (r < 6) begin
      return {1'b1, 15'($urandom)};
    end
    if (r < 14) begin
      return LenW'(lim + 1 + $urandom_range(0, 3));
    end
    if (r < 20) begin
      return LenW'((lim <= 48) ? lim : $urandom_range(13, 48));
    end
    return LenW'($urandom_range(0, (lim < 12) ? lim : 12));
  endfunction

  // Random byte with a bias toward the marker values, so that markers show
  // up inside payloads and noise far more often than by chance.
  function automatic logic [ByteW-1:0] pick_byte();
    if ($urandom_range(9) != 0) begin
      return ByteW'($urandom);
    end
    case ($urandom_range(3))
      0: return cur.start_first;
      1: return cur.start_second;
      2: return cur.end_first;
      default: return cur.end_second;
    endcase
  endfunction

  function automatic logic [ByteW-1:0] other_than(input logic [ByteW-1:0] x);
    logic [ByteW-1:0] b;
    do begin
      b = ByteW'($urandom);
    end while (b == x);
    return b;
  endfunction

  // A byte with its top bit set that matches neither start byte nor the
  // first end byte walks the parser back to hunting from any phase: a length
  // high byte like this is always rejected, and everywhere else it is a length
  // low byte or payload, or breaks the marker that is being looked for.
  function automatic logic [ByteW-1:0] flush_byte();
    logic [ByteW-1:0] b;
    do begin
      b = {1'b1, 7'($urandom)};
    end while (b == cur.start_first || b == cur.start_second || b == cur.end_first);
    return b;
  endfunction

  task automatic send_frame(input logic [LenW-1:0] len, input end_fault_e fault);
    push_byte(cur.start_first);
    // A repeated first start byte keeps the search waiting for the second.
    if (cur.start_first != cur.start_second && $urandom_range(7) == 0) begin
      push_byte(cur.start_first);
    end
    push_byte(cur.start_second);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    if (len[LenW-1] || int'(len) > length_limit()) begin
      return;
    end
    repeat (len) begin
      push_byte(pick_byte());
    end
    if (fault == END_BAD_FIRST) begin
      push_byte(other_than(cur.end_first));
      return;
    end
    push_byte(cur.end_first);
    push_byte((fault == END_BAD_SECOND) ? other_than(cur.end_second) : cur.end_second);
  endtask

  // Mostly well-formed frames with random content, and a fifth of the time a
  // short burst of noise that may start, break or extend a frame.
  task automatic random_bytes(input int unsigned n);
    int unsigned stop_at;
    int          r;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 20) begin
        repeat ($urandom_range(1, 4)) begin
          push_byte(pick_byte());
        end
      end else begin
        send_frame(pick_length(),
                   (r < 80) ? END_OK : ((r < 90) ? END_BAD_FIRST : END_BAD_SECOND));
      end
    end
  endtask

  // The sender holds off until every predicted result has been taken.
  task automatic pause_until_drained();
    byte_ch.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
  endtask

  // Brings the parser back to hunting and lets the block drain, so that the
  // registers can be rewritten with no frame in flight. The checker's state is
  // registered and lags the ports, so it is read only after a byte-free edge.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (in_frame) begin
      push_byte(flush_byte());
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Hand-picked stream under markers AA 55 / 0D 0A and a limit of 1024:
  // noise, a repeated first start byte, a two-byte payload with both byte
  // extremes and a good end; a zero-length frame with a bad second end byte;
  // a length with its top bit set; a zero-length frame with a bad first end
  // byte.
  task automatic directed_frames();
    logic [ByteW-1:0] seq [25];
    seq = '{8'h12, 8'hAA, 8'hAA, 8'h55, 8'h02, 8'h00, 8'h00, 8'hFF, 8'h0D, 8'h0A,
            8'hAA, 8'h55, 8'h00, 8'h00, 8'h0D, 8'h0B,
            8'hAA, 8'h55, 8'h01, 8'h80,
            8'hAA, 8'h55, 8'h00, 8'h00, 8'h77};
    foreach (seq[i]) begin
      push_byte(seq[i]);
    end
  endtask

  initial begin : stimulus
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= '0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    rst_ni          <= 1'b0;
    cur.start_first  = '0;
    cur.start_second = '0;
    cur.end_first    = '0;
    cur.end_second   = '0;
    cur.max_payload  = MaxPayloadReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: every marker byte is zero and the limit is 1024.
    set_idling(0, 0);
    random_bytes(40);
    settle();

    // Ordinary markers: the directed stream, then random traffic with a slow
    // sender and one pause in the middle until every result has come.
    apply_config(8'hAA, 8'h55, 8'h0D, 8'h0A, 15'd1024, 1'b0);
    directed_frames();
    settle();
    set_idling(52, 0);
    random_bytes(60);
    pause_until_drained();
    random_bytes(60);
    settle();

    // Both start bytes equal and a limit of zero: only empty frames pass.
    // Writes to the unused register indexes come along here.
    apply_config(8'hFF, 8'hFF, 8'h00, 8'hFF, 15'd0, 1'b1);
    set_idling(0, 52);
    random_bytes(80);
    settle();

    // Largest limit: the built-in 1024-byte ceiling decides, so a frame of
    // exactly 1024 bytes goes through and 1025 is turned away.
    apply_config(8'h00, 8'hFF, 8'hFF, 8'h00, 15'h7FFF, 1'b0);
    set_idling(36, 36);
    send_frame(LenW'(MaxFrameBytes), END_OK);
    send_frame(LenW'(MaxFrameBytes + 1), END_OK);
    random_bytes(30);
    settle();

    // Random markers with a small limit, no idling.
    apply_config(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                 MaxPayW'($urandom_range(1, 40)), 1'b0);
    set_idling(0, 0);
    random_bytes(100);
    settle();

    // One below the ceiling, with markers on either side of the top bit.
    apply_config(8'h80, 8'h7F, 8'h7F, 8'h80, 15'd1023, 1'b0);
    set_idling(36, 36);
    random_bytes(70);
    settle();

    $display("deframer run: %0d bytes under %0d register settings, %0d payload bytes checked,",
             bytes_sent, settings, kind_seen[KIND_DATA]);
    $display("  %0d good frames, %0d bad end markers, %0d rejected lengths, %0d mismatches",
             kind_seen[KIND_GOOD], kind_seen[KIND_BAD_END], kind_seen[KIND_REJECT], mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### marker_length_frame_deframer_top.f
hdl/mlfd_pkg.sv
hdl/mlfd_byte_if.sv
hdl/mlfd_result_if.sv
hdl/mlfd_cfg_regs.sv
hdl/mlfd_parser.sv
hdl/mlfd_out_stage.sv
hdl/marker_length_frame_deframer_top.sv
tb/mlfd_checker.sv
tb/testbench.sv
